/* design/sba_pkg.sv */
// ----------------------------------------------------------------------------
// sba_pkg
// Shared codes, widths, command/status structs and the order share table of
// the segregated block allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  // Fixed geometry
  localparam int NUM_ORDERS = 6;
  localparam int ORDER_W    = 3;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_FRAME_W = 20;
  localparam int TOTAL_W    = 11;
  localparam int BASE_W     = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int PCT_W      = 7;
  localparam int DIVISOR    = 100;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_ORDER = 2'd1,
    STAT_NONE      = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_PAGES = 1'b0,
    REG_BASE_FRAME  = 1'b1
  } cfg_reg_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic init_setup;
    logic exec;
    logic init_mul;
    logic init_rcp;
    logic init_cor;
    logic init_fill;
    logic next_order;
    logic init_done;
  } sba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_is_init;
    logic fill_done;
    logic last_order;
    logic out_busy;
  } sba_sts_t;

  // Percentage of the page count given to each order
  function automatic logic [PCT_W-1:0] share_pct(input logic [ORDER_W-1:0] k);
    logic [PCT_W-1:0] p;
    case (k)
      3'd0:    p = 7'd60;
      3'd1:    p = 7'd20;
      3'd2:    p = 7'd10;
      3'd3:    p = 7'd5;
      3'd4:    p = 7'd3;
      3'd5:    p = 7'd2;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

/* design/sba_if.sv */
// ----------------------------------------------------------------------------
// sba_if
// Valid/ready channels of the allocator: request in, response out.
// ----------------------------------------------------------------------------
interface sba_req_if;
  import sba_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [ORDER_W-1:0]    order;
  logic [IN_FRAME_W-1:0] frame;

  modport source (output valid, action, order, frame, input ready);
  modport sink   (input valid, action, order, frame, output ready);
endinterface

interface sba_rsp_if #(
  parameter int FRAME_BITS = 20
);
  import sba_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [FRAME_BITS-1:0] block_frame;

  modport source (output valid, status, block_frame, input ready);
  modport sink   (input valid, status, block_frame, output ready);
endinterface

/* design/segregated_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// segregated_block_allocator_core
// Page-block allocator with six fixed orders, each a FIFO free list.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request (action, order, frame); rsp_o returns exactly
//   one response (status, block_frame) per request, in request order.
//   total_pages and base_frame are written through the plain write port and
//   take effect at the next init; write them only while the block is idle.
//   Allocate and free: once accepted, the execute state reads or writes the
//   free block store and loads the result into the response register.
//   Init: the store is filled one entry per cycle, order 5 first; the
//   carving share of each order is worked out in a multiply, a reciprocal
//   and a correction step before its fill.
//   One request is in flight at a time. The response register holds a
//   result while rsp_o is stalled; a new request is taken in the cycle that
//   the pending response is taken.
//   Reset empties every order (allocate reports none free) and clears the
//   configuration; the store itself is not cleared.
// ----------------------------------------------------------------------------
module segregated_block_allocator_core #(
  parameter int MAX_PAGES  = 1024,
  parameter int FRAME_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sba_req_if.sink                        req_i,
  sba_rsp_if.source                      rsp_o
);
  import sba_pkg::*;

  sba_cmd_t cmd;
  sba_sts_t sts;
  logic     in_ready;

  assign req_i.ready = in_ready;

  // Sequencer
  sba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  sba_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_action_i  (req_i.action),
    .in_order_i   (req_i.order),
    .in_frame_i   (req_i.frame),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_status_o (rsp_o.status),
    .out_frame_o  (rsp_o.block_frame),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

/* design/sba_ctrl.sv */
// ----------------------------------------------------------------------------
// sba_ctrl
// Sequencer of the allocator: takes one request at a time, runs the execute
// state for allocate/free and the per-order carving walk for init.
// ----------------------------------------------------------------------------
module sba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sba_pkg::sba_sts_t sts_i,
  output sba_pkg::sba_cmd_t cmd_o
);
  import sba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_RCP,
    S_COR,
    S_FILL
  } state_e;

  state_e state_q, state_d;

  // Accept only when idle and the response register is free or draining
  assign in_ready_o = (state_q == S_IDLE) && !sts_i.out_busy;

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.accept = 1'b1;
          if (sts_i.req_is_init) begin
            cmd_o.init_setup = 1'b1;
            state_d          = S_MUL;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      S_MUL: begin
        cmd_o.init_mul = 1'b1;
        state_d        = S_RCP;
      end
      S_RCP: begin
        cmd_o.init_rcp = 1'b1;
        state_d        = S_COR;
      end
      S_COR: begin
        cmd_o.init_cor = 1'b1;
        state_d        = S_FILL;
      end
      S_FILL: begin
        if (!sts_i.fill_done) begin
          cmd_o.init_fill = 1'b1;
        end else if (sts_i.last_order) begin
          cmd_o.init_done = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.next_order = 1'b1;
          state_d          = S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/sba_dp.sv */
// ----------------------------------------------------------------------------
// sba_dp
// Datapath of the allocator: configuration registers, per-order queue
// pointers, the free block store, the share divider and the response register.
// ----------------------------------------------------------------------------
module sba_dp #(
  parameter int MAX_PAGES  = 1024,
  parameter int FRAME_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [sba_pkg::ACTION_W-1:0]   in_action_i,
  input  logic [sba_pkg::ORDER_W-1:0]    in_order_i,
  input  logic [sba_pkg::IN_FRAME_W-1:0] in_frame_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sba_pkg::STATUS_W-1:0]   out_status_o,
  output logic [FRAME_BITS-1:0]          out_frame_o,
  input  sba_pkg::sba_cmd_t              cmd_i,
  output sba_pkg::sba_sts_t              sts_o
);
  import sba_pkg::*;

  localparam int AW    = $clog2(MAX_PAGES);
  localparam int CW    = $clog2(MAX_PAGES + 1);
  localparam int MW    = CW + PCT_W;
  localparam int RS    = MW + 1;
  localparam int RW    = RS - 6;
  localparam longint RECIP_L = (64'd1 << RS) / DIVISOR;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  // Configuration
  logic [TOTAL_W-1:0] total_q;
  logic [BASE_W-1:0]  base_q;

  // Latched request
  logic [ACTION_W-1:0]   act_q;
  logic [ORDER_W-1:0]    ord_q;
  logic [IN_FRAME_W-1:0] frm_q;

  // Per-order queue state
  logic [AW-1:0] start_q [NUM_ORDERS];
  logic [CW-1:0] size_q  [NUM_ORDERS];
  logic [AW-1:0] head_q  [NUM_ORDERS];
  logic [AW-1:0] tail_q  [NUM_ORDERS];
  logic [CW-1:0] used_q  [NUM_ORDERS];

  // Carving state
  logic [CW-1:0]         n_q;
  logic [ORDER_W-1:0]    k_q;
  logic [CW-1:0]         slot_q;
  logic [FRAME_BITS-1:0] cur_frame_q;
  logic [MW-1:0]         m_q;
  logic [CW-1:0]         q0_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         fill_cnt_q;

  // Response
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_mem_q;
  logic [FRAME_BITS-1:0] rdata_q;

  // Store
  logic [FRAME_BITS-1:0] mem [MAX_PAGES];

  // Combinational
  logic                  ord_ok;
  logic [AW-1:0]         sel_start, sel_head, sel_tail;
  logic [CW-1:0]         sel_size, sel_used;
  logic                  alloc_ok, free_ok;
  logic [STATUS_W-1:0]   exec_status;
  logic [AW-1:0]         exec_addr;
  logic [CW-1:0]         head_ext, tail_ext;
  logic [AW-1:0]         head_nxt, tail_nxt;
  logic [MW-1:0]         m_d;
  logic [MW+RW-1:0]      rcp_prod;
  logic [MW-1:0]         rem;
  logic [CW-1:0]         count_d;
  logic [CW-1:0]         n_d;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [FRAME_BITS-1:0] mem_wdata;

  // Select the addressed order
  always_comb begin
    sel_start = '0;
    sel_head  = '0;
    sel_tail  = '0;
    sel_size  = '0;
    sel_used  = '0;
    for (int i = 0; i < NUM_ORDERS; i++) begin
      if (ord_q == ORDER_W'(i)) begin
        sel_start = start_q[i];
        sel_head  = head_q[i];
        sel_tail  = tail_q[i];
        sel_size  = size_q[i];
        sel_used  = used_q[i];
      end
    end
  end

  assign ord_ok   = (ord_q < ORDER_W'(NUM_ORDERS));
  assign alloc_ok = (act_q == ACT_ALLOC) && ord_ok && (sel_used < sel_size);
  assign free_ok  = (act_q == ACT_FREE) && ord_ok && (sel_used != '0);

  // Result code of an allocate or free
  always_comb begin
    case (act_q)
      ACT_INIT:  exec_status = STAT_OK;
      ACT_ALLOC: begin
        if (!ord_ok)                  exec_status = STAT_BAD_ORDER;
        else if (sel_used >= sel_size) exec_status = STAT_NONE;
        else                          exec_status = STAT_OK;
      end
      ACT_FREE: begin
        if (!ord_ok)              exec_status = STAT_BAD_ORDER;
        else if (sel_used == '0)  exec_status = STAT_NONE;
        else                      exec_status = STAT_OK;
      end
      default:   exec_status = STAT_BAD_ORDER;
    endcase
  end

  // Pop at the head, push at the tail; both wrap round the region
  assign exec_addr = sel_start + ((act_q == ACT_FREE) ? sel_tail : sel_head);
  assign head_ext  = CW'(sel_head) + CW'(1);
  assign tail_ext  = CW'(sel_tail) + CW'(1);
  assign head_nxt  = (head_ext == sel_size) ? '0 : AW'(head_ext);
  assign tail_nxt  = (tail_ext == sel_size) ? '0 : AW'(tail_ext);

  // Share of the page count: n * p, then divide by the constant via reciprocal
  assign n_d      = (32'(total_q) > MAX_PAGES) ? CW'(MAX_PAGES) : CW'(total_q);
  assign m_d      = {{PCT_W{1'b0}}, n_q} * {{CW{1'b0}}, share_pct(k_q)};
  assign rcp_prod = {{RW{1'b0}}, m_q} * {{MW{1'b0}}, RECIP};
  assign rem      = m_q - ({{(MW - CW){1'b0}}, q0_q} * MW'(DIVISOR));
  assign count_d  = (rem >= MW'(DIVISOR)) ? q0_q + CW'(1) : q0_q;

  // Store write port: carving fill or free
  assign mem_we    = cmd_i.init_fill || (cmd_i.exec && free_ok);
  assign mem_waddr = cmd_i.init_fill ? slot_q[AW-1:0] : exec_addr;
  assign mem_wdata = cmd_i.init_fill ? cur_frame_q : FRAME_BITS'(frm_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.exec && alloc_ok) begin
      rdata_q <= mem[exec_addr];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TOTAL_PAGES: total_q <= cfg_data_i[TOTAL_W-1:0];
        REG_BASE_FRAME:  base_q  <= cfg_data_i[BASE_W-1:0];
      endcase
    end
  end

  // Latch request
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= in_action_i;
      ord_q <= in_order_i;
      frm_q <= in_frame_i;
    end
  end

  // Carving walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      k_q         <= '0;
      slot_q      <= '0;
      cur_frame_q <= '0;
      count_q     <= '0;
      fill_cnt_q  <= '0;
    end else begin
      if (cmd_i.init_setup) begin
        n_q         <= n_d;
        k_q         <= ORDER_W'(NUM_ORDERS - 1);
        slot_q      <= '0;
        cur_frame_q <= FRAME_BITS'(base_q);
      end
      if (cmd_i.init_cor) begin
        count_q    <= count_d;
        fill_cnt_q <= '0;
      end
      if (cmd_i.init_fill) begin
        slot_q      <= slot_q + CW'(1);
        fill_cnt_q  <= fill_cnt_q + CW'(1);
        cur_frame_q <= cur_frame_q + (FRAME_BITS'(1) << k_q);
      end
      if (cmd_i.next_order) begin
        k_q <= k_q - ORDER_W'(1);
      end
    end
  end

  // Divider pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_mul) begin
      m_q <= m_d;
    end
    if (cmd_i.init_rcp) begin
      q0_q <= rcp_prod[RS +: CW];
    end
  end

  // Per-order pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ORDERS; i++) begin
        start_q[i] <= '0;
        size_q[i]  <= '0;
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        used_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_ORDERS; i++) begin
        if (cmd_i.init_cor && (k_q == ORDER_W'(i))) begin
          start_q[i] <= slot_q[AW-1:0];
          size_q[i]  <= count_d;
          head_q[i]  <= '0;
          tail_q[i]  <= '0;
          used_q[i]  <= '0;
        end
        if (cmd_i.exec && alloc_ok && (ord_q == ORDER_W'(i))) begin
          head_q[i] <= head_nxt;
          used_q[i] <= used_q[i] + CW'(1);
        end
        if (cmd_i.exec && free_ok && (ord_q == ORDER_W'(i))) begin
          tail_q[i] <= tail_nxt;
          used_q[i] <= used_q[i] - CW'(1);
        end
      end
    end
  end

  // Response register: load at the end of an item, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_OK;
      out_mem_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.exec || cmd_i.init_done) begin
        out_valid_q  <= 1'b1;
        out_status_q <= cmd_i.exec ? exec_status : STAT_OK;
        out_mem_q    <= cmd_i.exec && alloc_ok;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_frame_o  = out_mem_q ? rdata_q : '0;

  assign sts_o.req_is_init = (in_action_i == ACT_INIT);
  assign sts_o.fill_done   = (fill_cnt_q == count_q);
  assign sts_o.last_order  = (k_q == '0);
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

endmodule

/* design/sba_checker.sv */
// ----------------------------------------------------------------------------
// sba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sba_checker #(
  parameter int FRAME_BITS = 20
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [sba_pkg::ACTION_W-1:0] in_action_i,
  input logic [sba_pkg::ORDER_W-1:0]  in_order_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [sba_pkg::STATUS_W-1:0] out_status_i,
  input logic [FRAME_BITS-1:0]        out_frame_i
);
  import sba_pkg::*;

  logic in_acc;
  logic bad_req;

  assign in_acc  = in_valid_i && in_ready_i;
  assign bad_req = (in_action_i != ACT_INIT) &&
                   ((in_action_i != ACT_ALLOC && in_action_i != ACT_FREE) ||
                    (in_order_i >= ORDER_W'(NUM_ORDERS)));

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_status_i) && $stable(out_frame_i))
    else $error("response changed while stalled");

  // A failed request never carries a frame
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != STAT_OK) |-> (out_frame_i == '0))
    else $error("frame returned on failed request");

  // One request in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("request taken while busy");

  // Allocate and free answer once the execute state loads the response
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_action_i != ACT_INIT) |=> !out_valid_i ##1 out_valid_i)
    else $error("allocate/free response latency wrong");

  // Bad order or action reports invalid
  a_bad_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && bad_req |-> ##2 (out_valid_i && (out_status_i == STAT_BAD_ORDER)))
    else $error("invalid request not reported");

endmodule

bind segregated_block_allocator_core sba_checker #(
  .FRAME_BITS (FRAME_BITS)
) u_sba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .in_action_i  (req_i.action),
  .in_order_i   (req_i.order),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_status_i (rsp_o.status),
  .out_frame_i  (rsp_o.block_frame)
);

/* sim/segregated_block_allocator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segregated_block_allocator_core_tb
// Drives init, allocate, free and unused-action requests with random gaps
// and response stalls, predicts every response from a local copy of the
// free lists and compares each response with the oldest prediction.
// ----------------------------------------------------------------------------
module segregated_block_allocator_core_tb;
  import sba_pkg::*;

  localparam int MAX_PAGES  = 1024;
  localparam int FRAME_BITS = 20;
  localparam int TARGET_REQUESTS = 1950;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    status_e               status;
    logic [FRAME_BITS-1:0] frame;
  } grant_t;

  typedef struct packed {
    logic [ORDER_W-1:0]    order;
    logic [FRAME_BITS-1:0] frame;
  } held_t;

  // Mirror of the free lists and the queue of responses still owed
  class grant_predictor;
    logic [FRAME_BITS-1:0] block_store [MAX_PAGES];
    int unsigned first_slot [NUM_ORDERS];
    int unsigned blocks_in [NUM_ORDERS];
    int unsigned oldest [NUM_ORDERS];
    int unsigned handed_out [NUM_ORDERS];
    int unsigned order_share [NUM_ORDERS] = '{60, 20, 10, 5, 3, 2};
    int unsigned total_pages;
    logic [FRAME_BITS-1:0] base_frame;
    grant_t pending_grants [$];
    int unsigned failures;

    function new();
      foreach (first_slot[k]) begin
        first_slot[k] = 0;
        blocks_in[k]  = 0;
        oldest[k]     = 0;
        handed_out[k] = 0;
      end
      total_pages = 0;
      base_frame  = '0;
      failures    = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TOTAL_PAGES) begin
        total_pages = data[TOTAL_W-1:0];
      end else begin
        base_frame = data[BASE_W-1:0];
      end
    endfunction

    // Rebuild every order, largest first, blocks laid out upward from base
    function void carve();
      int unsigned pages;
      int unsigned count;
      int unsigned slot;
      int unsigned offset;
      int k;
      pages  = (total_pages > MAX_PAGES) ? MAX_PAGES : total_pages;
      slot   = 0;
      offset = 0;
      for (k = NUM_ORDERS - 1; k >= 0; k--) begin
        count = (pages * order_share[k]) / 100;
        first_slot[k] = slot;
        blocks_in[k]  = count;
        oldest[k]     = 0;
        handed_out[k] = 0;
        for (int j = 0; j < count; j++) begin
          if (slot < MAX_PAGES) block_store[slot] = base_frame + offset[FRAME_BITS-1:0];
          slot++;
          offset += 1 << k;
        end
      end
    endfunction

    function grant_t take_request(logic [ACTION_W-1:0] action, logic [ORDER_W-1:0] order,
                                  logic [FRAME_BITS-1:0] frame);
      grant_t g;
      int unsigned k;
      int unsigned idx;
      g.status = STAT_OK;
      g.frame  = '0;
      k = order;
      if (action == ACT_INIT) begin
        carve();
      end else if (action == ACT_UNUSED || order >= NUM_ORDERS) begin
        g.status = STAT_BAD_ORDER;
      end else if (action == ACT_ALLOC) begin
        if (handed_out[k] >= blocks_in[k]) begin
          g.status = STAT_NONE;
        end else begin
          idx = first_slot[k] + oldest[k];
          if (idx < MAX_PAGES) g.frame = block_store[idx];
          oldest[k] = (oldest[k] + 1) % blocks_in[k];
          handed_out[k]++;
        end
      end else begin
        if (handed_out[k] == 0 || blocks_in[k] == 0) begin
          g.status = STAT_NONE;
        end else begin
          // tail sits behind the oldest entry by the number of blocks handed out
          idx = first_slot[k] +
                (oldest[k] + blocks_in[k] - handed_out[k]) % blocks_in[k];
          if (idx < MAX_PAGES) block_store[idx] = frame;
          handed_out[k]--;
        end
      end
      pending_grants.push_back(g);
      return g;
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic [FRAME_BITS-1:0] frame);
      grant_t want;
      if (pending_grants.size() == 0) begin
        failures++;
        $display("%0t: response without request: status %0d frame %05h", $time, status, frame);
        return;
      end
      want = pending_grants.pop_front();
      if (status !== want.status) begin
        failures++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
      end
      if (frame !== want.frame) begin
        failures++;
        $display("%0t: block_frame expected %05h, got %05h", $time, want.frame, frame);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sba_req_if req_if ();
  sba_rsp_if #(.FRAME_BITS(FRAME_BITS)) rsp_if ();

  segregated_block_allocator_core #(
    .MAX_PAGES (MAX_PAGES),
    .FRAME_BITS(FRAME_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  grant_predictor predictor;
  held_t          held_blocks [$];
  int unsigned    requests_sent;
  bit             steady_flow;

  always #6 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 6);
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(logic [ACTION_W-1:0] action, logic [ORDER_W-1:0] order,
                              logic [FRAME_BITS-1:0] frame);
    int unsigned gap;
    grant_t g;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= action;
    req_if.order  <= order;
    req_if.frame  <= frame;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    g = predictor.take_request(action, order, frame);
    requests_sent++;
    if (action == ACT_INIT) begin
      held_blocks.delete();
    end else if (action == ACT_ALLOC && g.status == STAT_OK) begin
      held_blocks.push_back('{order: order, frame: g.frame});
    end
  endtask

  // Drop valid and hold until every response is back
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (predictor.pending_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    predictor.write_reg(idx, data);
  endtask

  // Reconfigure while idle, then rebuild the lists with an init request
  task automatic start_layout(int unsigned pages, logic [BASE_W-1:0] base);
    wait_idle();
    write_reg(REG_TOTAL_PAGES, CFG_DATA_W'(pages));
    write_reg(REG_BASE_FRAME, base);
    send_request(ACT_INIT, ORDER_W'($urandom), FRAME_BITS'($urandom));
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned slot;
    held_t blk;
    logic [ORDER_W-1:0] ord;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      ord = ($urandom_range(0, 19) == 0) ? ORDER_W'($urandom_range(6, 7))
                                         : ORDER_W'($urandom_range(0, 5));
      send_request(ACT_ALLOC, ord, FRAME_BITS'($urandom));
    end else if (pick < 80) begin
      // mostly hand back blocks that were really given out
      if (held_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
        slot = $urandom_range(0, held_blocks.size() - 1);
        blk  = held_blocks[slot];
        held_blocks.delete(slot);
        send_request(ACT_FREE, blk.order, blk.frame);
      end else begin
        send_request(ACT_FREE, ORDER_W'($urandom_range(0, 5)), FRAME_BITS'($urandom));
      end
    end else if (pick < 90) begin
      send_request($urandom_range(0, 1) ? ACT_ALLOC : ACT_FREE,
                   ORDER_W'($urandom_range(6, 7)), FRAME_BITS'($urandom));
    end else if (pick < 95) begin
      send_request(ACT_UNUSED, ORDER_W'($urandom), FRAME_BITS'($urandom));
    end else if (pick < 97) begin
      send_request(ACT_INIT, ORDER_W'($urandom), FRAME_BITS'($urandom));
    end else begin
      send_request(ACT_FREE, ORDER_W'($urandom_range(0, 5)), FRAME_BITS'($urandom));
    end
  endtask

  // Response side: stall at random, check every response taken
  initial begin
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int unsigned stall;
      stall = draw_gap();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (rsp_if.valid !== 1'b1) @(posedge clk_i);
      predictor.check_response(rsp_if.status, rsp_if.block_frame);
    end
  end

  // Stimulus
  initial begin
    int unsigned pages;
    int unsigned run_len;
    logic [BASE_W-1:0] base;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_TOTAL_PAGES;
    cfg_data_i    = '0;
    req_if.valid  = 1'b0;
    req_if.action = ACT_INIT;
    req_if.order  = '0;
    req_if.frame  = '0;
    steady_flow   = 1'b0;
    requests_sent = 0;
    predictor     = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing carved yet: allocate and free both find nothing
    send_request(ACT_ALLOC, 3'd0, 20'h00000);
    send_request(ACT_FREE, 3'd3, 20'h12345);

    // oversized page count, frames wrapping past the top
    start_layout(2047, 20'hFFF00);
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      send_request(ACT_ALLOC, ORDER_W'(k), 20'h00000);
    end
    send_request(ACT_ALLOC, 3'd6, 20'h00000);
    send_request(ACT_FREE, 3'd7, 20'hFFFFF);
    send_request(ACT_UNUSED, 3'd0, 20'h00000);
    send_request(ACT_FREE, 3'd0, 20'hFFFFF);
    send_request(ACT_FREE, 3'd0, 20'h00000);

    // one page: every order empty
    start_layout(1, 20'h00000);
    send_request(ACT_ALLOC, 3'd0, 20'h00000);

    // five pages: a single order-1 block, recycled through a free
    start_layout(5, 20'h00010);
    send_request(ACT_ALLOC, 3'd1, 20'h00000);
    send_request(ACT_ALLOC, 3'd1, 20'h00000);
    send_request(ACT_FREE, 3'd1, 20'hABCDE);
    send_request(ACT_ALLOC, 3'd1, 20'h00000);
    send_request(ACT_FREE, 3'd5, 20'h55555);

    start_layout(1024, 20'h00000);
    send_request(ACT_ALLOC, 3'd0, 20'h00000);

    // random phases, each with its own layout
    while (requests_sent < TARGET_REQUESTS) begin
      case ($urandom_range(0, 7))
        0:       pages = 0;
        1:       pages = 1;
        2:       pages = 1024;
        3:       pages = 2047;
        4:       pages = $urandom_range(1025, 2047);
        5, 6:    pages = $urandom_range(2, 64);
        default: pages = $urandom_range(0, 1024);
      endcase
      case ($urandom_range(0, 3))
        0:       base = 20'h00000;
        1:       base = 20'hFFFFF;
        2:       base = 20'hFFFFF - BASE_W'($urandom_range(0, 1500));
        default: base = BASE_W'($urandom);
      endcase
      start_layout(pages, base);
      steady_flow = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(30, 90);
      repeat (run_len) random_request();
      steady_flow = 1'b0;
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (predictor.failures == 0 && predictor.pending_grants.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
design/sba_pkg.sv
design/sba_if.sv
design/sba_ctrl.sv
design/sba_dp.sv
design/segregated_block_allocator_core.sv
design/sba_checker.sv
sim/segregated_block_allocator_core_tb.sv
